// ----- design/ultrasonic_ranging_controller_assert.svh -----
// Assertion macros for the ultrasonic ranging controller.
// Clocked on i_clk, disabled while i_rst_n is low; no other dependencies.
`ifndef ULTRASONIC_RANGING_CONTROLLER_ASSERT_SVH
`define ULTRASONIC_RANGING_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define URC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define URC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/urc_pkg.sv -----
// Shared types and constants of the ultrasonic ranging controller.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package urc_pkg;

    localparam int PRESCALE_W = 10;
    localparam logic [PRESCALE_W-1:0] TICKS_PER_MS = 10'd1000;

    localparam logic [3:0] TRIG_LOW_US  = 4'd2;
    localparam logic [3:0] TRIG_HIGH_US = 4'd10;

    localparam logic [15:0] MS_MAX  = 16'hFFFF;
    localparam logic [23:0] DUR_MAX = 24'hFFFFFF;

    localparam logic [15:0] PING_INTERVAL_RST = 16'd60;
    localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd30;

    localparam logic [1:0] CFG_PING_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_ECHO_TIMEOUT  = 2'd1;

    // duration * 17 / 1000 reaches 65536 from this duration on
    localparam logic [23:0] DUR_SAT_LIMIT = 24'd3855059;
    // ceil(2^30 / 125): exact quotient by 125 for operands below 2^23
    localparam logic [23:0] DIV125_MUL = 24'd8589935;
    localparam int DIV125_SHIFT = 30;

    typedef enum logic [3:0] {
        MODE_IDLE      = 4'b0001,
        MODE_TRIG_LOW  = 4'b0010,
        MODE_TRIG_HIGH = 4'b0100,
        MODE_WAIT      = 4'b1000
    } t_mode;

    typedef struct packed {
        logic        trigger_level;
        logic        distance_valid;
        logic [15:0] distance_cm;
        logic        waiting_echo;
        logic        timed_out;
    } t_result;

endpackage

// ----- design/urc_range_calc.sv -----
// Echo duration to distance conversion: duration * 17 / 1000, saturated to 16 bits.
// Depends on urc_pkg for the reciprocal constants.
`timescale 1ns / 1ps

module urc_range_calc (
    input  logic [23:0] i_duration_us,
    output logic [15:0] o_distance_cm
);

    logic [26:0] w_scaled;
    logic [22:0] w_eighth;
    logic [46:0] w_product;

    // times 17 by shift-add, then /8 by shift and /125 by reciprocal
    assign w_scaled  = {1'b0, i_duration_us[21:0], 4'b0000} + {5'b00000, i_duration_us[21:0]};
    assign w_eighth  = w_scaled[25:3];
    assign w_product = {24'd0, w_eighth} * {23'd0, urc_pkg::DIV125_MUL};

    always_comb begin
        if (i_duration_us >= urc_pkg::DUR_SAT_LIMIT) begin
            o_distance_cm = 16'hFFFF;
        end else begin
            o_distance_cm = w_product[urc_pkg::DIV125_SHIFT +: 16];
        end
    end

endmodule

// ----- design/urc_core.sv -----
// Ranging state: millisecond time base, trigger sequencer, echo timing, timeout.
// Depends on urc_pkg, urc_range_calc and the assertion macro header.
`timescale 1ns / 1ps
`include "ultrasonic_ranging_controller_assert.svh"

module urc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_accept,
    input  logic             i_echo_level,
    output urc_pkg::t_result o_result
);

    urc_pkg::t_mode                  r_mode,    n_mode;
    logic [urc_pkg::PRESCALE_W-1:0]  r_pre,     n_pre;
    logic [15:0]                     r_ms,      n_ms;
    logic [3:0]                      r_pc,      n_pc;
    logic                            r_prev,    n_prev;
    logic                            r_started, n_started;
    logic [23:0]                     r_dur,     n_dur;
    logic [15:0]                     r_ping_ms;
    logic [15:0]                     r_tmo_ms;

    logic [15:0] w_calc_cm;

    logic        w_in_trig_low;
    logic        w_trig_phase;
    logic [43:0] w_state;
    logic        w_no_report;

    urc_range_calc u_calc (
        .i_duration_us (r_dur),
        .o_distance_cm (w_calc_cm)
    );

    always_comb begin
        n_mode    = r_mode;
        n_pc      = r_pc;
        n_started = r_started;
        n_dur     = r_dur;
        n_ms      = r_ms;
        o_result  = '0;

        // advance the millisecond time base
        n_pre = r_pre + 1'b1;
        if (n_pre >= urc_pkg::TICKS_PER_MS) begin
            n_pre = '0;
            if (r_ms != urc_pkg::MS_MAX) begin
                n_ms = r_ms + 16'd1;
            end
        end

        // abandon the wait
        if (r_mode == urc_pkg::MODE_WAIT && n_ms > r_tmo_ms) begin
            n_mode             = urc_pkg::MODE_IDLE;
            n_started          = 1'b0;
            o_result.timed_out = 1'b1;
        end

        // echo edges
        if (i_echo_level && !r_prev) begin
            n_started = 1'b1;
            n_dur     = 24'd1;
        end else if (i_echo_level) begin
            if (n_started && r_dur != urc_pkg::DUR_MAX) begin
                n_dur = r_dur + 24'd1;
            end
        end else if (r_prev && n_started) begin
            o_result.distance_valid = 1'b1;
            o_result.distance_cm    = w_calc_cm;
            n_started               = 1'b0;
            if (n_mode == urc_pkg::MODE_WAIT) begin
                n_mode = urc_pkg::MODE_IDLE;
            end
        end
        n_prev = i_echo_level;

        // trigger pulse and new ping
        case (n_mode)
            urc_pkg::MODE_TRIG_LOW: begin
                n_pc = r_pc + 4'd1;
                if (n_pc >= urc_pkg::TRIG_LOW_US) begin
                    n_mode = urc_pkg::MODE_TRIG_HIGH;
                    n_pc   = '0;
                end
            end
            urc_pkg::MODE_TRIG_HIGH: begin
                o_result.trigger_level = 1'b1;
                n_pc = r_pc + 4'd1;
                if (n_pc >= urc_pkg::TRIG_HIGH_US) begin
                    n_mode = urc_pkg::MODE_WAIT;
                    n_pc   = '0;
                end
            end
            urc_pkg::MODE_IDLE: begin
                if (n_ms > r_ping_ms) begin
                    n_ms   = '0;
                    n_pre  = '0;
                    n_mode = urc_pkg::MODE_TRIG_LOW;
                    n_pc   = 4'd1;
                end
            end
            default: begin
            end
        endcase

        o_result.waiting_echo = (n_mode != urc_pkg::MODE_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= urc_pkg::MODE_IDLE;
            r_pre     <= '0;
            r_ms      <= '0;
            r_pc      <= '0;
            r_prev    <= 1'b0;
            r_started <= 1'b0;
            r_dur     <= '0;
        end else if (i_accept) begin
            r_mode    <= n_mode;
            r_pre     <= n_pre;
            r_ms      <= n_ms;
            r_pc      <= n_pc;
            r_prev    <= n_prev;
            r_started <= n_started;
            r_dur     <= n_dur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ping_ms <= urc_pkg::PING_INTERVAL_RST;
            r_tmo_ms  <= urc_pkg::ECHO_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == urc_pkg::CFG_PING_INTERVAL) begin
                r_ping_ms <= i_cfg_data;
            end else if (i_cfg_index == urc_pkg::CFG_ECHO_TIMEOUT) begin
                r_tmo_ms <= i_cfg_data;
            end
        end
    end

    assign w_in_trig_low = i_accept && r_mode == urc_pkg::MODE_TRIG_LOW;
    assign w_trig_phase  = r_mode == urc_pkg::MODE_TRIG_LOW || r_mode == urc_pkg::MODE_TRIG_HIGH;
    assign w_state       = {r_mode, r_dur, r_ms};
    assign w_no_report   = !r_started || o_result.distance_valid == 1'b0;

    `URC_ASSERT_SAME(a_pre_range, 1'b1, r_pre < urc_pkg::TICKS_PER_MS, "prescaler out of range")
    `URC_ASSERT_NEXT(a_low_to_high, w_in_trig_low, w_trig_phase, "trigger low phase left wrongly")
    `URC_ASSERT_NEXT(a_hold_idle, !i_accept, $stable(w_state), "state moved without a transfer")
    `URC_ASSERT_SAME(a_report_idle, o_result.timed_out, w_no_report, "report on a timeout tick")

endmodule

// ----- design/urc_out_buf.sv -----
// Result register with a skid stage between the core and the output channel.
// Depends on urc_pkg for the result type.
`timescale 1ns / 1ps

module urc_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  urc_pkg::t_result i_result,
    input  logic             i_out_stall,
    output logic             o_full,
    output logic             o_out_valid,
    output urc_pkg::t_result o_out
);

    logic             r_out_valid;
    logic             r_skid_valid;
    urc_pkg::t_result r_out;
    urc_pkg::t_result r_skid;
    logic             w_free;

    assign w_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_accept;
            end
        end else if (i_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (i_accept) begin
                r_out <= i_result;
            end
        end else if (i_accept) begin
            r_skid <= i_result;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- design/ultrasonic_ranging_controller.sv -----
// Ultrasonic echo ranging controller: one transfer on the input channel is one
// microsecond tick with the sampled echo level, and each tick yields exactly one
// result transfer. A tick is taken every clock cycle; results pass through a
// result register and a one-entry skid stage, so input stalls only once two
// results wait downstream. The whole tick is resolved combinationally, the
// distance by a shift-add and one reciprocal multiply. Ping interval and echo
// timeout are set through the write port, index 0 and 1.
`timescale 1ns / 1ps

module ultrasonic_ranging_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_echo_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_trigger_level,
    output logic        o_distance_valid,
    output logic [15:0] o_distance_cm,
    output logic        o_waiting_echo,
    output logic        o_timed_out
);

    logic             w_accept;
    logic             w_full;
    urc_pkg::t_result w_result;
    urc_pkg::t_result w_out;

    assign w_accept = i_valid && !w_full;
    assign o_stall  = w_full;

    urc_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_echo_level (i_echo_level),
        .o_result     (w_result)
    );

    urc_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_result    (w_result),
        .i_out_stall (i_stall),
        .o_full      (w_full),
        .o_out_valid (o_valid),
        .o_out       (w_out)
    );

    assign o_trigger_level  = w_out.trigger_level;
    assign o_distance_valid = w_out.distance_valid;
    assign o_distance_cm    = w_out.distance_cm;
    assign o_waiting_echo   = w_out.waiting_echo;
    assign o_timed_out      = w_out.timed_out;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for ultrasonic_ranging_controller: a directed table, then random
// echo traffic under four idle/stall mixes, all checked against a cycle-free tick predictor.
// Depends on urc_pkg (types, constants) and the controller RTL.
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [31:0] SOUND_MUL = 32'd17;
    localparam logic [31:0] SOUND_DIV = 32'd1000;
    localparam logic [31:0] CM_LIMIT  = 32'd65535;

    localparam int PHASES = 4;
    localparam int PH_SRC_IDLE [PHASES]   = '{0, 77, 0, 28};
    localparam int PH_SINK_STALL [PHASES] = '{0, 0, 77, 28};
    localparam int PHASE_REPORTS   = 12;
    localparam int PHASE_MIN_TICKS = 125;
    localparam int PHASE_MAX_TICKS = 40000;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum logic [2:0] {
        DIR_TICK, DIR_HOLD_N, DIR_HOLD_MODE, DIR_HOLD_TMO, DIR_CFG
    } t_dir_kind;

    typedef enum logic [2:0] {
        GEN_QUIET, GEN_DELAY, GEN_HIGH, GEN_AIM, GEN_NOISE
    } t_gen_state;

    typedef struct packed {
        t_dir_kind        kind;
        logic             echo;
        logic [19:0]      count;
        urc_pkg::t_mode   until_mode;
        logic [1:0]       cfg_idx;
        logic [15:0]      cfg_val;
        logic             pinned;
        urc_pkg::t_result pin;
    } t_dir_row;

    localparam urc_pkg::t_result RES_QUIET = '0;
    localparam urc_pkg::t_result RES_IDLE_REPORT = '{trigger_level: 1'b0,
                                                     distance_valid: 1'b1,
                                                     distance_cm: 16'd0,
                                                     waiting_echo: 1'b0,
                                                     timed_out: 1'b0};

    localparam int DIR_ROWS = 24;
    localparam t_dir_row DIR_TBL [DIR_ROWS] = '{
        '{DIR_TICK,      1'b0, 20'd1,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b1, RES_QUIET},
        '{DIR_TICK,      1'b1, 20'd1,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b1, RES_QUIET},
        '{DIR_TICK,      1'b0, 20'd1,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b1, RES_IDLE_REPORT},
        '{DIR_CFG,       1'b0, 20'd0,     urc_pkg::MODE_IDLE,
          CFG_SPARE_2,                16'hFFFF, 1'b0, RES_QUIET},
        '{DIR_CFG,       1'b0, 20'd0,     urc_pkg::MODE_IDLE,
          CFG_SPARE_3,                16'h0000, 1'b0, RES_QUIET},
        '{DIR_CFG,       1'b0, 20'd0,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_CFG,       1'b0, 20'd0,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_ECHO_TIMEOUT,  16'd0,    1'b0, RES_QUIET},
        '{DIR_HOLD_MODE, 1'b0, 20'd0,     urc_pkg::MODE_TRIG_LOW,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        // echo pulse inside the trigger pulse
        '{DIR_TICK,      1'b1, 20'd1,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_TICK,      1'b0, 20'd1,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_HOLD_MODE, 1'b0, 20'd0,     urc_pkg::MODE_WAIT,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_HOLD_N,    1'b1, 20'd500,   urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_TICK,      1'b0, 20'd1,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_HOLD_MODE, 1'b0, 20'd0,     urc_pkg::MODE_TRIG_LOW,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_HOLD_MODE, 1'b0, 20'd0,     urc_pkg::MODE_WAIT,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        // hold echo high until the timeout tick, then drop it on that tick
        '{DIR_HOLD_TMO,  1'b1, 20'd0,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_TICK,      1'b0, 20'd1,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_CFG,       1'b0, 20'd0,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_ECHO_TIMEOUT,  16'hFFFF, 1'b0, RES_QUIET},
        '{DIR_HOLD_MODE, 1'b0, 20'd0,     urc_pkg::MODE_WAIT,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_HOLD_N,    1'b0, 20'd3000,  urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_HOLD_N,    1'b1, 20'd60000, urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_TICK,      1'b0, 20'd1,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET},
        '{DIR_CFG,       1'b0, 20'd0,     urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'hFFFF, 1'b0, RES_QUIET},
        '{DIR_HOLD_N,    1'b0, 20'd2500,  urc_pkg::MODE_IDLE,
          urc_pkg::CFG_PING_INTERVAL, 16'd0,    1'b0, RES_QUIET}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic        i_echo_level;
    logic        o_valid;
    logic        i_stall;
    logic        o_trigger_level;
    logic        o_distance_valid;
    logic [15:0] o_distance_cm;
    logic        o_waiting_echo;
    logic        o_timed_out;

    // tick predictor state and its copy of the registers
    urc_pkg::t_mode rng_mode;
    logic [9:0]     rng_presc;
    logic [15:0]    rng_ms;
    logic [3:0]     rng_pulse;
    logic           rng_echo_q;
    logic           rng_started;
    logic [23:0]    rng_dur_us;
    logic [15:0]    cfg_ping_ms;
    logic [15:0]    cfg_tmo_ms;

    urc_pkg::t_result pending_results [$];
    logic             pin_on;
    urc_pkg::t_result pin_res;

    t_gen_state  gen_state;
    logic        gen_armed;
    int unsigned gen_delay;
    int unsigned gen_width;

    int          src_idle_pct;
    int          sink_stall_pct;
    int unsigned tick_count;
    int unsigned report_count;
    int unsigned ping_count;
    int unsigned timeout_count;
    int          err_count;

    ultrasonic_ranging_controller u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_echo_level     (i_echo_level),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_trigger_level  (o_trigger_level),
        .o_distance_valid (o_distance_valid),
        .o_distance_cm    (o_distance_cm),
        .o_waiting_echo   (o_waiting_echo),
        .o_timed_out      (o_timed_out)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    function automatic urc_pkg::t_result ranging_step(input logic echo);
        urc_pkg::t_result r;
        logic [31:0]      cm;
        r = '0;
        rng_presc = rng_presc + 10'd1;
        if (rng_presc >= urc_pkg::TICKS_PER_MS) begin
            rng_presc = '0;
            if (rng_ms != urc_pkg::MS_MAX) rng_ms = rng_ms + 16'd1;
        end
        if (rng_mode == urc_pkg::MODE_WAIT && rng_ms > cfg_tmo_ms) begin
            rng_mode = urc_pkg::MODE_IDLE;
            rng_started = 1'b0;
            r.timed_out = 1'b1;
        end
        if (echo && !rng_echo_q) begin
            rng_started = 1'b1;
            rng_dur_us = 24'd1;
        end else if (echo) begin
            if (rng_started && rng_dur_us != urc_pkg::DUR_MAX) begin
                rng_dur_us = rng_dur_us + 24'd1;
            end
        end else if (rng_echo_q && rng_started) begin
            cm = ({8'd0, rng_dur_us} * SOUND_MUL) / SOUND_DIV;
            r.distance_cm = (cm > CM_LIMIT) ? CM_LIMIT[15:0] : cm[15:0];
            r.distance_valid = 1'b1;
            rng_started = 1'b0;
            if (rng_mode == urc_pkg::MODE_WAIT) rng_mode = urc_pkg::MODE_IDLE;
        end
        rng_echo_q = echo;
        case (rng_mode)
            urc_pkg::MODE_TRIG_LOW: begin
                rng_pulse = rng_pulse + 4'd1;
                if (rng_pulse >= urc_pkg::TRIG_LOW_US) begin
                    rng_mode = urc_pkg::MODE_TRIG_HIGH;
                    rng_pulse = '0;
                end
            end
            urc_pkg::MODE_TRIG_HIGH: begin
                r.trigger_level = 1'b1;
                rng_pulse = rng_pulse + 4'd1;
                if (rng_pulse >= urc_pkg::TRIG_HIGH_US) begin
                    rng_mode = urc_pkg::MODE_WAIT;
                    rng_pulse = '0;
                end
            end
            urc_pkg::MODE_IDLE: begin
                if (rng_ms > cfg_ping_ms) begin
                    rng_ms = '0;
                    rng_presc = '0;
                    rng_mode = urc_pkg::MODE_TRIG_LOW;
                    rng_pulse = 4'd1;
                end
            end
            default: ;
        endcase
        r.waiting_echo = (rng_mode != urc_pkg::MODE_IDLE);
        return r;
    endfunction

    // true when the next tick abandons the echo wait
    function automatic logic timeout_next();
        logic [15:0] ms_next;
        ms_next = (rng_ms == urc_pkg::MS_MAX) ? rng_ms : rng_ms + 16'd1;
        return rng_mode == urc_pkg::MODE_WAIT
               && rng_presc == urc_pkg::TICKS_PER_MS - 10'd1
               && ms_next > cfg_tmo_ms;
    endfunction

    task automatic check_result(input urc_pkg::t_result want, input urc_pkg::t_result got);
        if (got.trigger_level !== want.trigger_level) begin
            $error("trigger_level: expected %0d, got %0d", want.trigger_level,
                   got.trigger_level);
            err_count++;
        end
        if (got.distance_valid !== want.distance_valid) begin
            $error("distance_valid: expected %0d, got %0d", want.distance_valid,
                   got.distance_valid);
            err_count++;
        end
        if (got.distance_cm !== want.distance_cm) begin
            $error("distance_cm: expected %0d, got %0d", want.distance_cm, got.distance_cm);
            err_count++;
        end
        if (got.waiting_echo !== want.waiting_echo) begin
            $error("waiting_echo: expected %0d, got %0d", want.waiting_echo,
                   got.waiting_echo);
            err_count++;
        end
        if (got.timed_out !== want.timed_out) begin
            $error("timed_out: expected %0d, got %0d", want.timed_out, got.timed_out);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        urc_pkg::t_result pred;
        urc_pkg::t_result got;
        if (!i_rst_n) begin
            rng_mode = urc_pkg::MODE_IDLE;
            rng_presc = '0;
            rng_ms = '0;
            rng_pulse = '0;
            rng_echo_q = 1'b0;
            rng_started = 1'b0;
            rng_dur_us = '0;
            tick_count = 0;
            report_count = 0;
            ping_count = 0;
            timeout_count = 0;
            err_count = 0;
        end else begin
            if (i_valid && !o_stall) begin
                pred = ranging_step(i_echo_level);
                tick_count++;
                if (pred.distance_valid) report_count++;
                if (pred.timed_out) timeout_count++;
                if (rng_mode == urc_pkg::MODE_TRIG_LOW) ping_count++;
                pending_results.push_back(pin_on ? pin_res : pred);
            end
            if (o_valid && !i_stall) begin
                got = {o_trigger_level, o_distance_valid, o_distance_cm, o_waiting_echo,
                       o_timed_out};
                if (pending_results.size() == 0) begin
                    $error("result transfer with no tick outstanding");
                    err_count++;
                end else begin
                    check_result(pending_results.pop_front(), got);
                end
            end
        end
    end

    // call at a falling edge; returns at the falling edge after the transfer
    task automatic push_tick(input logic echo);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_echo_level <= echo;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            urc_pkg::CFG_PING_INTERVAL: cfg_ping_ms = val;
            urc_pkg::CFG_ECHO_TIMEOUT:  cfg_tmo_ms = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic next_echo();
        logic        e;
        logic        in_pulse;
        int unsigned r;
        e = 1'b0;
        in_pulse = (rng_mode == urc_pkg::MODE_TRIG_LOW || rng_mode == urc_pkg::MODE_TRIG_HIGH);
        if (gen_state == GEN_QUIET) begin
            if (in_pulse) gen_armed = 1'b1;
            if (rng_mode == urc_pkg::MODE_WAIT && gen_armed) begin
                gen_armed = 1'b0;
                r = (cfg_tmo_ms > 16'd3) ? 0 : $urandom_range(99);
                gen_delay = $urandom_range(300);
                if (r < 55) begin
                    gen_state = GEN_DELAY;
                    gen_width = 1 + $urandom_range(cfg_tmo_ms == 16'd0 ? 600 : 1500);
                end else if (r < 70) begin
                    gen_state = GEN_DELAY;
                    gen_width = 0;
                end else if (r >= 82) begin
                    gen_state = GEN_NOISE;
                    gen_width = 1 + $urandom_range(40);
                end
            end else if (in_pulse && $urandom_range(15) == 0) begin
                gen_state = GEN_NOISE;
                gen_width = 1 + $urandom_range(5);
            end else if (rng_mode == urc_pkg::MODE_IDLE && $urandom_range(999) == 0) begin
                gen_state = GEN_NOISE;
                gen_width = 1 + $urandom_range(20);
            end
        end
        if (gen_state == GEN_DELAY) begin
            if (gen_delay == 0) gen_state = (gen_width == 0) ? GEN_AIM : GEN_HIGH;
            else gen_delay--;
        end
        case (gen_state)
            GEN_HIGH: begin
                e = 1'b1;
                gen_width--;
                if (gen_width == 0) gen_state = GEN_QUIET;
            end
            GEN_AIM: begin
                // drop the echo on the tick the wait is abandoned
                if (rng_mode != urc_pkg::MODE_WAIT || timeout_next()) gen_state = GEN_QUIET;
                else e = 1'b1;
            end
            GEN_NOISE: begin
                e = $urandom_range(1);
                gen_width--;
                if (gen_width == 0) gen_state = GEN_QUIET;
            end
            default: e = 1'b0;
        endcase
        return e;
    endfunction

    task automatic run_episode();
        logic [15:0] ping;
        logic [15:0] tmo;
        int unsigned r;
        int unsigned pings0;
        int unsigned ticks0;
        int unsigned target;
        int unsigned cap;
        r = $urandom_range(99);
        ping = (r < 60) ? 16'd0 : (r < 75) ? 16'd1 : (r < 85) ? 16'd2 :
               (r < 92) ? 16'($urandom_range(65535)) : 16'hFFFF;
        r = $urandom_range(99);
        tmo = (r < 45) ? 16'd0 : (r < 70) ? 16'd1 : (r < 80) ? 16'd2 :
              (r < 88) ? 16'($urandom_range(65535)) : 16'hFFFF;
        if ($urandom_range(9) == 0)
            write_reg($urandom_range(1) ? CFG_SPARE_3 : CFG_SPARE_2, 16'($urandom_range(65535)));
        write_reg(urc_pkg::CFG_PING_INTERVAL, ping);
        write_reg(urc_pkg::CFG_ECHO_TIMEOUT, tmo);
        target = 1 + $urandom_range(2);
        cap = (ping > 16'd4) ? 2000 : 9000;
        pings0 = ping_count;
        ticks0 = tick_count;
        while (ping_count - pings0 < target && tick_count - ticks0 < cap)
            push_tick(next_echo());
    endtask

    initial begin
        int unsigned reports0;
        int unsigned ticks0;
        cfg_ping_ms = urc_pkg::PING_INTERVAL_RST;
        cfg_tmo_ms = urc_pkg::ECHO_TIMEOUT_RST;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        pin_on = 1'b0;
        pin_res = RES_QUIET;
        gen_state = GEN_QUIET;
        gen_armed = 1'b0;
        gen_delay = 0;
        gen_width = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= urc_pkg::CFG_PING_INTERVAL;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_echo_level <= 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (DIR_TBL[i]) begin
            t_dir_row row;
            row = DIR_TBL[i];
            pin_on = row.pinned;
            pin_res = row.pin;
            case (row.kind)
                DIR_TICK:      push_tick(row.echo);
                DIR_HOLD_N:    repeat (row.count) push_tick(row.echo);
                DIR_HOLD_MODE: while (rng_mode != row.until_mode) push_tick(row.echo);
                DIR_HOLD_TMO:  while (!timeout_next()) push_tick(row.echo);
                DIR_CFG:       write_reg(row.cfg_idx, row.cfg_val);
                default: ;
            endcase
        end
        pin_on = 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            src_idle_pct = PH_SRC_IDLE[ph];
            sink_stall_pct = PH_SINK_STALL[ph];
            reports0 = report_count;
            ticks0 = tick_count;
            while ((report_count - reports0 < PHASE_REPORTS
                    || tick_count - ticks0 < PHASE_MIN_TICKS)
                   && tick_count - ticks0 < PHASE_MAX_TICKS)
                run_episode();
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d ticks with %0d pings, %0d distance reports, %0d echo timeouts",
                 tick_count, ping_count, report_count, timeout_count);
        $display("Both registers swept from 0 to 65535 under four idle/stall mixes");
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #60_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
